// ===== rtl/lcs_pkg.sv =====
// Shared constants, status codes and the sequencer program of the congruence solver.
package lcs_pkg;

  localparam int VALUE_BITS = 31;
  localparam int STATUS_W   = 2;
  localparam int PC_W       = 5;

  localparam logic [STATUS_W-1:0] STATUS_SOLVED   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_MOD = 2'd2;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_DIV_EU,
    OP_MUL_EU,
    OP_EU_UPD,
    OP_DIV_BD,
    OP_TAKE_B,
    OP_DIV_ND,
    OP_TAKE_M,
    OP_DIV_BM,
    OP_TAKE_BR,
    OP_FIX_NEG,
    OP_FIX_BIG,
    OP_MUL_FIN,
    OP_DIV_PM,
    OP_FIN_SOLVED,
    OP_FIN_NONE,
    OP_FIN_ZMOD
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_R0_ZERO,
    C_R1_ZERO,
    C_REM_NONZERO
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  localparam logic [PC_W-1:0] PC_START   = 5'd0;
  localparam logic [PC_W-1:0] PC_EU_LOOP = 5'd1;
  localparam logic [PC_W-1:0] PC_EU_EXIT = 5'd5;
  localparam logic [PC_W-1:0] PC_ZMOD    = 5'd17;
  localparam logic [PC_W-1:0] PC_NONE    = 5'd18;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      5'd0:    w = '{op: OP_NOP,        cond: C_R0_ZERO,     target: PC_ZMOD};
      5'd1:    w = '{op: OP_NOP,        cond: C_R1_ZERO,     target: PC_EU_EXIT};
      5'd2:    w = '{op: OP_DIV_EU,     cond: C_NEVER,       target: PC_START};
      5'd3:    w = '{op: OP_MUL_EU,     cond: C_NEVER,       target: PC_START};
      5'd4:    w = '{op: OP_EU_UPD,     cond: C_ALWAYS,      target: PC_EU_LOOP};
      5'd5:    w = '{op: OP_DIV_BD,     cond: C_NEVER,       target: PC_START};
      5'd6:    w = '{op: OP_NOP,        cond: C_REM_NONZERO, target: PC_NONE};
      5'd7:    w = '{op: OP_TAKE_B,     cond: C_NEVER,       target: PC_START};
      5'd8:    w = '{op: OP_DIV_ND,     cond: C_NEVER,       target: PC_START};
      5'd9:    w = '{op: OP_TAKE_M,     cond: C_NEVER,       target: PC_START};
      5'd10:   w = '{op: OP_DIV_BM,     cond: C_NEVER,       target: PC_START};
      5'd11:   w = '{op: OP_TAKE_BR,    cond: C_NEVER,       target: PC_START};
      5'd12:   w = '{op: OP_FIX_NEG,    cond: C_NEVER,       target: PC_START};
      5'd13:   w = '{op: OP_FIX_BIG,    cond: C_NEVER,       target: PC_START};
      5'd14:   w = '{op: OP_MUL_FIN,    cond: C_NEVER,       target: PC_START};
      5'd15:   w = '{op: OP_DIV_PM,     cond: C_NEVER,       target: PC_START};
      5'd16:   w = '{op: OP_FIN_SOLVED, cond: C_NEVER,       target: PC_START};
      5'd17:   w = '{op: OP_FIN_ZMOD,   cond: C_NEVER,       target: PC_START};
      5'd18:   w = '{op: OP_FIN_NONE,   cond: C_NEVER,       target: PC_START};
      default: w = '{op: OP_FIN_NONE,   cond: C_NEVER,       target: PC_START};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/linear_congruence_solver.sv =====
// Linear congruence solver: microcoded extended-Euclid sequencer with a shared divider.
// The time from accept to result grows with the number of Euclid steps (at most 45 at
// 31 bits); the Euclid divides and the double-width final reduction all run on one
// radix-2 divider, which sets the rate. A new request is taken only once the previous
// one has finished, and the next request is taken while a result waits. Reset:
// asynchronous, active low; clears sequencer, divider count and output valid only.
module linear_congruence_solver #(
  parameter int VALUE_BITS = lcs_pkg::VALUE_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // coefficient, right_side, modulus
  input  logic [((3*VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // solution
  output logic [((VALUE_BITS+7)/8)*8-1:0]       m_axis_tdata_o,
  // status
  output logic [lcs_pkg::STATUS_W-1:0]          m_axis_tuser_o
);

  localparam int VW = VALUE_BITS;
  localparam int TW = VW + 1;
  localparam int PW = 2 * TW;
  localparam int NW = 2 * VW;
  localparam int CW = $clog2(NW + 1);

  lcs_pkg::ucode_t uw;

  logic                          busy_q, busy_d;
  logic                          wait_q, wait_d;
  logic [lcs_pkg::PC_W-1:0]      pc_q, pc_d;
  logic                          out_valid_q, out_valid_d;
  logic [VW-1:0]                 sol_q, sol_d;
  logic [lcs_pkg::STATUS_W-1:0]  status_q, status_d;

  logic [VW-1:0]                 r0_q, r0_d, r1_q, r1_d;
  logic signed [TW-1:0]          t0_q, t0_d, t1_q, t1_d;
  logic [VW-1:0]                 b_q, b_d, n_q, n_d, m_q, m_d;
  logic signed [PW-1:0]          prod_q, prod_d;
  logic [NW-1:0]                 num_q, num_d;
  logic [VW-1:0]                 rem_q, rem_d, den_q, den_d;
  logic [CW-1:0]                 cnt_q, cnt_d;

  logic signed [TW-1:0]          mul_a, mul_b, m_ext;
  logic signed [PW-1:0]          mul_p;
  logic [VW:0]                   shift_val;
  logic [VW+1:0]                 diff;
  logic                          div_busy, is_div, cond_true, step_go;
  logic [VW-1:0]                 div_x, div_y;

  assign uw       = lcs_pkg::ucode_rom(pc_q);
  assign div_busy = (cnt_q != '0);
  assign is_div   = (uw.op == lcs_pkg::OP_DIV_EU) || (uw.op == lcs_pkg::OP_DIV_BD) ||
                    (uw.op == lcs_pkg::OP_DIV_ND) || (uw.op == lcs_pkg::OP_DIV_BM) ||
                    (uw.op == lcs_pkg::OP_DIV_PM);

  assign mul_a = (uw.op == lcs_pkg::OP_MUL_FIN) ? $signed({1'b0, b_q})
                                                : $signed({1'b0, num_q[VW-1:0]});
  assign mul_b = (uw.op == lcs_pkg::OP_MUL_FIN) ? t0_q : t1_q;
  assign mul_p = mul_a * mul_b;
  assign m_ext = $signed({1'b0, m_q});

  assign shift_val = {rem_q, num_q[NW-1]};
  assign diff      = {1'b0, shift_val} - {2'b00, den_q};

  always_comb begin
    unique case (uw.cond)
      lcs_pkg::C_NEVER:       cond_true = 1'b0;
      lcs_pkg::C_ALWAYS:      cond_true = 1'b1;
      lcs_pkg::C_R0_ZERO:     cond_true = (r0_q == '0);
      lcs_pkg::C_R1_ZERO:     cond_true = (r1_q == '0);
      lcs_pkg::C_REM_NONZERO: cond_true = (rem_q != '0);
      default:                cond_true = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uw.op)
      lcs_pkg::OP_DIV_EU: begin
        div_x = r0_q;
        div_y = r1_q;
      end
      lcs_pkg::OP_DIV_BD: begin
        div_x = b_q;
        div_y = r0_q;
      end
      lcs_pkg::OP_DIV_ND: begin
        div_x = n_q;
        div_y = r0_q;
      end
      default: begin
        div_x = b_q;
        div_y = m_q;
      end
    endcase
  end

  always_comb begin
    if (is_div) begin
      step_go = wait_q && !div_busy;
    end else if ((uw.op == lcs_pkg::OP_FIN_SOLVED) || (uw.op == lcs_pkg::OP_FIN_NONE) ||
                 (uw.op == lcs_pkg::OP_FIN_ZMOD)) begin
      step_go = !out_valid_q || m_axis_tready_i;
    end else begin
      step_go = 1'b1;
    end
  end

  always_comb begin
    busy_d      = busy_q;
    wait_d      = wait_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q;
    sol_d       = sol_q;
    status_d    = status_q;
    r0_d        = r0_q;
    r1_d        = r1_q;
    t0_d        = t0_q;
    t1_d        = t1_q;
    b_d         = b_q;
    n_d         = n_q;
    m_d         = m_q;
    prod_d      = prod_q;
    num_d       = num_q;
    rem_d       = rem_q;
    den_d       = den_q;
    cnt_d       = cnt_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    if (div_busy) begin
      cnt_d = cnt_q - CW'(1);
      if (!diff[VW+1]) begin
        rem_d = diff[VW-1:0];
        num_d = {num_q[NW-2:0], 1'b1};
      end else begin
        rem_d = shift_val[VW-1:0];
        num_d = {num_q[NW-2:0], 1'b0};
      end
    end

    if (!busy_q) begin
      if (s_axis_tvalid_i) begin
        busy_d = 1'b1;
        wait_d = 1'b0;
        pc_d   = lcs_pkg::PC_START;
        r1_d   = s_axis_tdata_i[VW-1:0];
        b_d    = s_axis_tdata_i[2*VW-1:VW];
        r0_d   = s_axis_tdata_i[3*VW-1:2*VW];
        n_d    = s_axis_tdata_i[3*VW-1:2*VW];
        t0_d   = '0;
        t1_d   = TW'(1);
      end
    end else if (is_div && !wait_q) begin
      wait_d = 1'b1;
      rem_d  = '0;
      if (uw.op == lcs_pkg::OP_DIV_PM) begin
        den_d = m_q;
        num_d = prod_q[NW-1:0];
        cnt_d = CW'(NW);
      end else begin
        den_d = div_y;
        num_d = {div_x, {VW{1'b0}}};
        cnt_d = CW'(VW);
      end
    end else if (step_go) begin
      wait_d = 1'b0;
      pc_d   = cond_true ? uw.target : pc_q + lcs_pkg::PC_W'(1);
      unique case (uw.op)
        lcs_pkg::OP_MUL_EU, lcs_pkg::OP_MUL_FIN: begin
          prod_d = mul_p;
        end
        lcs_pkg::OP_EU_UPD: begin
          r0_d = r1_q;
          r1_d = rem_q;
          t0_d = t1_q;
          t1_d = t0_q - prod_q[TW-1:0];
        end
        lcs_pkg::OP_TAKE_B: begin
          b_d = num_q[VW-1:0];
        end
        lcs_pkg::OP_TAKE_M: begin
          m_d = num_q[VW-1:0];
        end
        lcs_pkg::OP_TAKE_BR: begin
          b_d = rem_q;
        end
        lcs_pkg::OP_FIX_NEG: begin
          if (t0_q[TW-1]) begin
            t0_d = t0_q + m_ext;
          end
        end
        lcs_pkg::OP_FIX_BIG: begin
          if (t0_q >= m_ext) begin
            t0_d = t0_q - m_ext;
          end
        end
        lcs_pkg::OP_FIN_SOLVED: begin
          busy_d      = 1'b0;
          out_valid_d = 1'b1;
          sol_d       = rem_q;
          status_d    = lcs_pkg::STATUS_SOLVED;
        end
        lcs_pkg::OP_FIN_NONE: begin
          busy_d      = 1'b0;
          out_valid_d = 1'b1;
          sol_d       = '0;
          status_d    = lcs_pkg::STATUS_NONE;
        end
        lcs_pkg::OP_FIN_ZMOD: begin
          busy_d      = 1'b0;
          out_valid_d = 1'b1;
          sol_d       = '0;
          status_d    = lcs_pkg::STATUS_ZERO_MOD;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      wait_q      <= 1'b0;
      pc_q        <= lcs_pkg::PC_START;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      wait_q      <= wait_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sol_q    <= sol_d;
    status_q <= status_d;
    r0_q     <= r0_d;
    r1_q     <= r1_d;
    t0_q     <= t0_d;
    t1_q     <= t1_d;
    b_q      <= b_d;
    n_q      <= n_d;
    m_q      <= m_d;
    prod_q   <= prod_d;
    num_q    <= num_d;
    rem_q    <= rem_d;
    den_q    <= den_d;
  end

  always_comb begin
    m_axis_tdata_o         = '0;
    m_axis_tdata_o[VW-1:0] = sol_q;
  end

  assign s_axis_tready_o = !busy_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;

endmodule

// ===== rtl/lcs_checker.sv =====
// Port-level assertions for the congruence solver and their bind to the top level.
module lcs_checker #(
  parameter int VALUE_BITS = lcs_pkg::VALUE_BITS
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid_i,
  input logic                                 s_axis_tready_i,
  input logic                                 m_axis_tvalid_i,
  input logic                                 m_axis_tready_i,
  // solution
  input logic [((VALUE_BITS+7)/8)*8-1:0]      m_axis_tdata_i,
  // status
  input logic [lcs_pkg::STATUS_W-1:0]         m_axis_tuser_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_i |=> !s_axis_tready_i)
    else $error("request accepted while busy");

  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready_i) |-> m_axis_tvalid_i)
    else $error("sequencer freed without a result");

  a_zero_unless_solved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (m_axis_tuser_i != lcs_pkg::STATUS_SOLVED) |-> m_axis_tdata_i == '0)
    else $error("nonzero solution without a solve");

endmodule

bind linear_congruence_solver lcs_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_lcs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);
